/* design/atq_pkg.sv */
// Shared types and constants of the absmean ternary quantizer.
`default_nettype none
package atq_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 17;
	localparam int MEAN_W   = 16;
	localparam int TRIT_W   = 2;

	localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'd0;
	localparam logic [TRIT_W-1:0] TRIT_POS  = 2'd1;
	localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       group_end;
	} in_item_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic [TRIT_W-1:0]         trit;
		logic [MEAN_W-1:0]         mean_scale;
		logic                      run_end;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // store the accepted sample
		logic div_start;  // group closes with this sample
		logic rd_first;   // fetch the first stored sample
		logic rd_next;    // fetch the following stored sample
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic close;      // incoming sample ends the group
		logic div_done;   // mean is ready
		logic emit_last;  // shown result is the group's last
	} dp_status_t;

endpackage
`default_nettype wire

/* design/atq_chan_if.sv */
// Valid/ready channel carrying one payload per transaction.
`default_nettype none
interface atq_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/atq_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module atq_div #(
	parameter int DVD_W = 22,
	parameter int DVS_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* design/atq_ctrl.sv */
// Controller: load, divide and emit sequencing with channel handshakes.
`default_nettype none
module atq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire atq_pkg::dp_status_t status,
	output atq_pkg::dp_cmd_t      cmd
);
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PREP = 2'd2;
	localparam logic [1:0] ST_SHOW = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_xfer;
	logic       out_xfer;

	assign in_ready  = state_q == ST_LOAD;
	assign out_valid = state_q == ST_SHOW;
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;

	// commands to the datapath
	always_comb begin
		cmd.load      = in_xfer;
		cmd.div_start = in_xfer && status.close;
		cmd.rd_first  = state_q == ST_PREP;
		cmd.rd_next   = out_xfer && !status.emit_last;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && status.close) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_xfer && status.emit_last) state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

/* design/atq_dp.sv */
// Datapath: sample store, magnitude sum, mean divider and result forming.
`default_nettype none
module atq_dp #(
	parameter int GROUP_MAX = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire atq_pkg::in_item_t in_item,
	input  wire atq_pkg::dp_cmd_t  cmd,
	output atq_pkg::dp_status_t    status,
	output atq_pkg::out_item_t     out_item
);
	localparam int AW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
	localparam int CW = $clog2(GROUP_MAX + 1);
	localparam int SW = $clog2(GROUP_MAX * 32768 + 1);
	localparam int SMP_W = atq_pkg::SAMPLE_W;
	localparam int LVL_W = atq_pkg::LEVEL_W;
	localparam int MW = atq_pkg::MEAN_W;

	logic signed [SMP_W-1:0] mem [GROUP_MAX];
	logic signed [SMP_W-1:0] rd_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic [SW-1:0]           sum_q;
	logic [CW-1:0]           fill_inc;
	logic [CW-1:0]           idx_inc;
	logic [SW-1:0]           sum_next;
	logic [LVL_W-1:0]        in_ext;
	logic [LVL_W-1:0]        in_mag;
	logic [LVL_W-1:0]        rd_ext;
	logic [LVL_W-1:0]        rd_mag;
	logic [AW-1:0]           rd_addr;
	logic                    div_done;
	logic [SW-1:0]           quotient;
	logic [MW-1:0]           mean;
	logic                    hit;

	// magnitude of the incoming sample and the running sum
	always_comb begin
		in_ext   = LVL_W'(in_item.sample);
		in_mag   = in_item.sample[SMP_W-1] ? LVL_W'(~in_ext + 1'b1) : in_ext;
		fill_inc = CW'(fill_q + 1'b1);
		sum_next = SW'(sum_q + SW'(in_mag));
	end

	assign status.close = in_item.group_end || (fill_inc == CW'(GROUP_MAX));

	// fill count and magnitude sum; clear when the group closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.load) begin
			if (cmd.div_start) begin
				fill_q <= '0;
				sum_q  <= '0;
			end else begin
				fill_q <= fill_inc;
				sum_q  <= sum_next;
			end
		end
	end

	// group size and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.div_start) count_q <= fill_inc;
			if (cmd.rd_first) begin
				idx_q <= '0;
			end else if (cmd.rd_next) begin
				idx_q <= idx_inc;
			end
		end
	end

	assign idx_inc = CW'(idx_q + 1'b1);
	assign rd_addr = cmd.rd_first ? '0 : idx_inc[AW-1:0];

	// sample store, registered read
	always_ff @(posedge clk) begin
		if (cmd.load) mem[fill_q[AW-1:0]] <= in_item.sample;
		if (cmd.rd_first || cmd.rd_next) rd_q <= mem[rd_addr];
	end

	atq_div #(
		.DVD_W(SW),
		.DVS_W(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_next),
		.divisor (fill_inc),
		.done    (div_done),
		.quotient(quotient)
	);

	assign mean             = quotient[MW-1:0];
	assign status.div_done  = div_done;
	assign status.emit_last = idx_inc == count_q;

	// threshold the fetched sample against the mean
	always_comb begin
		rd_ext = LVL_W'(rd_q);
		rd_mag = rd_q[SMP_W-1] ? LVL_W'(~rd_ext + 1'b1) : rd_ext;
		hit    = (mean != '0) && (rd_mag >= LVL_W'(mean));
		out_item.mean_scale = mean;
		out_item.run_end    = status.emit_last;
		if (!hit) begin
			out_item.level = '0;
			out_item.trit  = atq_pkg::TRIT_ZERO;
		end else if (rd_q[SMP_W-1]) begin
			out_item.level = LVL_W'(~LVL_W'(mean) + 1'b1);
			out_item.trit  = atq_pkg::TRIT_NEG;
		end else begin
			out_item.level = LVL_W'(mean);
			out_item.trit  = atq_pkg::TRIT_POS;
		end
	end
endmodule
`default_nettype wire

/* design/absmean_ternary_quantizer.sv */
// Flow: a group of N samples loads at one sample per cycle while samples are valid;
// the close starts a restoring divider with a clog2(GROUP_MAX*32768+1)-bit dividend
// (22 bits at 64); its done flag moves the controller to a prep state that fetches
// the first sample, then one result per cycle while the output is ready; no input
// is taken while a group divides or emits. Reset: arst_n clears the controller,
// fill count, sum and divider control; the sample store is not cleared.
`default_nettype none
module absmean_ternary_quantizer #(
	parameter int GROUP_MAX = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	atq_chan_if.sink    samples,
	atq_chan_if.source  results
);
	atq_pkg::dp_cmd_t    cmd;
	atq_pkg::dp_status_t status;
	atq_pkg::in_item_t   in_item;
	atq_pkg::out_item_t  out_item;

	assign in_item         = samples.payload;
	assign results.payload = out_item;

	atq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.status   (status),
		.cmd      (cmd)
	);

	atq_dp #(
		.GROUP_MAX(GROUP_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.cmd     (cmd),
		.status  (status),
		.out_item(out_item)
	);
endmodule
`default_nettype wire

/* tb/tb_absmean_ternary_quantizer.sv */
// Self-checking testbench of the absmean ternary quantizer with its own group predictor.
`default_nettype none
module tb_absmean_ternary_quantizer;
	import atq_pkg::*;

	localparam int GROUP_MAX    = 64;
	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 106;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT      = 30;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DIR_ROWS     = 24;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       grp_end;
		logic                       typed;
		out_item_t                  want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	atq_chan_if #(.payload_t(in_item_t))  samples_if ();
	atq_chan_if #(.payload_t(out_item_t)) results_if ();

	absmean_ternary_quantizer #(
		.GROUP_MAX(GROUP_MAX)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.results(results_if)
	);

	// predictor state: samples of the open group and their magnitude sum
	logic signed [SAMPLE_W-1:0] open_group[$];
	logic [21:0]                mag_acc;
	out_item_t                  quant_due[$];
	int                         mismatch_count;
	int                         results_seen;
	int                         items_sent;

	dir_row_t dir_table [DIR_ROWS] = '{
		'{16'sd4096,   1'b1, 1'b1, '{17'sd4096,   TRIT_POS,  16'd4096,  1'b1}},
		'{-16'sd32768, 1'b1, 1'b1, '{-17'sd32768, TRIT_NEG,  16'd32768, 1'b1}},
		'{16'sd32767,  1'b1, 1'b1, '{17'sd32767,  TRIT_POS,  16'd32767, 1'b1}},
		'{16'sd0,      1'b1, 1'b1, '{17'sd0,      TRIT_ZERO, 16'd0,     1'b1}},
		'{-16'sd1,     1'b1, 1'b1, '{-17'sd1,     TRIT_NEG,  16'd1,     1'b1}},
		'{16'sd1,      1'b1, 1'b1, '{17'sd1,      TRIT_POS,  16'd1,     1'b1}},
		// all-zero group
		'{16'sd0,      1'b0, 1'b0, '0},
		'{16'sd0,      1'b0, 1'b0, '0},
		'{16'sd0,      1'b1, 1'b0, '0},
		// most negative values only
		'{-16'sd32768, 1'b0, 1'b0, '0},
		'{-16'sd32768, 1'b0, 1'b0, '0},
		'{-16'sd32768, 1'b1, 1'b0, '0},
		// small values fall below the mean
		'{16'sd5,      1'b0, 1'b0, '0},
		'{16'sd2,      1'b0, 1'b0, '0},
		'{16'sd2,      1'b0, 1'b0, '0},
		'{-16'sd9,     1'b1, 1'b0, '0},
		// truncated mean lets a value equal to it through
		'{16'sd3,      1'b0, 1'b0, '0},
		'{-16'sd3,     1'b0, 1'b0, '0},
		'{16'sd2,      1'b1, 1'b0, '0},
		// both extremes in one group
		'{16'sd32767,  1'b0, 1'b0, '0},
		'{-16'sd32768, 1'b0, 1'b0, '0},
		'{16'sd100,    1'b0, 1'b0, '0},
		'{-16'sd100,   1'b1, 1'b0, '0},
		'{-16'sd4096,  1'b1, 1'b1, '{-17'sd4096,  TRIT_NEG,  16'd4096,  1'b1}}
	};

	// print one mismatch line and count it
	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// absorb one accepted sample; on group close, queue the quantized levels
	task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
		logic [MEAN_W-1:0] mag;
		logic [MEAN_W-1:0] mean;
		logic [21:0]       quot;
		out_item_t         item;
		int                n;
		mag = s[SAMPLE_W-1] ? (~s + 16'd1) : s;
		open_group.push_back(s);
		mag_acc = mag_acc + 22'(mag);
		n = open_group.size();
		if (last || n == GROUP_MAX) begin
			quot = mag_acc / 22'(n);
			mean = quot[MEAN_W-1:0];
			for (int i = 0; i < n; i++) begin
				mag = open_group[i][SAMPLE_W-1] ? (~open_group[i] + 16'd1) : open_group[i];
				item.level      = '0;
				item.trit       = TRIT_ZERO;
				item.mean_scale = mean;
				item.run_end    = (i == n - 1);
				if (mean != 0 && mag >= mean) begin
					if (!open_group[i][SAMPLE_W-1]) begin
						item.level = {1'b0, mean};
						item.trit  = TRIT_POS;
					end else begin
						item.level = -$signed({1'b0, mean});
						item.trit  = TRIT_NEG;
					end
				end
				quant_due.push_back(item);
			end
			open_group.delete();
			mag_acc = '0;
		end
	endtask

	// offer one transaction after a random gap, then update the prediction
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
		int gap;
		gap = (items_sent >= 60 && items_sent < 95) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid           <= 1'b1;
		samples_if.payload.sample    <= s;
		samples_if.payload.group_end <= last;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		items_sent++;
		absorb_sample(s, last);
	endtask

	// mix of full-range, small, near +-4096 and extreme values
	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		logic [31:0]                r;
		logic signed [SAMPLE_W-1:0] v;
		r = $urandom;
		case ($urandom_range(0, 5))
			0, 1: v = r[15:0];
			2: begin
				v = 16'($urandom_range(0, 31));
				if (r[0]) v = -v;
			end
			3: v = 16'sd4096 + 16'($urandom_range(0, 400)) - 16'sd200;
			4: v = -16'sd4096 + 16'($urandom_range(0, 400)) - 16'sd200;
			default: begin
				case (r[1:0])
					2'd0: v = -16'sd32768;
					2'd1: v = 16'sd32767;
					2'd2: v = 16'sd0;
					default: v = -16'sd1;
				endcase
			end
		endcase
		return v;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	initial begin
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls, one long hold-off, field-by-field check
	initial begin
		int        gap;
		bit        held;
		out_item_t got;
		out_item_t want;
		results_if.ready = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && results_seen == HOLD_AT) begin
				held = 1'b1;
				gap  = HOLD_CYCLES;
			end else if (results_seen >= 70 && results_seen < 120) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 9);
			end
			if (gap > 0) begin
				results_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			@(posedge clk);
			while (!results_if.valid) @(posedge clk);
			got = results_if.payload;
			results_seen++;
			if (quant_due.size() == 0) begin
				flag_mismatch($sformatf("result with nothing due, level %0d",
					int'(got.level)));
			end else begin
				want = quant_due.pop_front();
				if (got.level !== want.level)
					flag_mismatch($sformatf("level got %0d want %0d",
						int'(got.level), int'(want.level)));
				if (got.trit !== want.trit)
					flag_mismatch($sformatf("trit got %0d want %0d", got.trit, want.trit));
				if (got.mean_scale !== want.mean_scale)
					flag_mismatch($sformatf("mean_scale got %0d want %0d",
						got.mean_scale, want.mean_scale));
				if (got.run_end !== want.run_end)
					flag_mismatch($sformatf("run_end got %0b want %0b",
						got.run_end, want.run_end));
			end
		end
	end

	// reset, directed table, random groups, drain
	initial begin
		int  random_sent;
		int  grp_len;
		bit  full_done;
		arst_n                       = 1'b0;
		samples_if.valid             = 1'b0;
		samples_if.payload.sample    = '0;
		samples_if.payload.group_end = 1'b0;
		mag_acc                      = '0;
		mismatch_count               = 0;
		results_seen                 = 0;
		items_sent                   = 0;
		random_sent                  = 0;
		full_done                    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; typed rows replace the predicted item
		for (int r = 0; r < DIR_ROWS; r++) begin
			send_sample(dir_table[r].sample, dir_table[r].grp_end);
			if (dir_table[r].typed) begin
				void'(quant_due.pop_back());
				quant_due.push_back(dir_table[r].want);
			end
		end

		// random groups; the first fills the buffer with no end flag
		while (random_sent < RANDOM_ITEMS) begin
			if (!full_done) begin
				grp_len   = GROUP_MAX;
				full_done = 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				grp_len = GROUP_MAX;
			end else begin
				grp_len = $urandom_range(1, 8);
			end
			// keep the total within the item budget
			if (grp_len > RANDOM_ITEMS - random_sent) grp_len = RANDOM_ITEMS - random_sent;
			for (int i = 0; i < grp_len; i++) begin
				if (i == grp_len - 1 && grp_len == GROUP_MAX && random_sent < GROUP_MAX)
					send_sample(draw_sample(), 1'b0);
				else if (i == grp_len - 1)
					send_sample(draw_sample(), grp_len == GROUP_MAX ? 1'($urandom) : 1'b1);
				else
					send_sample(draw_sample(), 1'b0);
				random_sent++;
			end
		end
		samples_if.valid <= 1'b0;

		// drain, then watch for stray results
		while (quant_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
